[rtl/brwt_pkg.sv]
// ----------------------------------------------------------------------------
// brwt_pkg
// Types and codes shared by the range window translation block.
// ----------------------------------------------------------------------------
package brwt_pkg;

   localparam int CSR_WIDTH   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_XLATE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  entry_index;
      logic [31:0] win_child_space;
      logic [31:0] win_child_base;
      logic [31:0] win_parent_space;
      logic [31:0] win_parent_base;
      logic [31:0] win_size;
      logic [31:0] req_space;
      logic [31:0] req_addr;
      logic [31:0] req_size;
      logic [31:0] req_offset;
      logic [31:0] req_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_space;
      logic [31:0] out_addr;
      logic [31:0] out_size;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_XLATE   = 2'd1,
      KIND_INVALID = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  entry_index;
      logic [31:0] win_child_space;
      logic [31:0] win_child_base;
      logic [31:0] win_parent_space;
      logic [31:0] win_parent_base;
      logic [31:0] win_size;
      logic [31:0] xl_space;
      logic [31:0] xl_size;
   } queue_item_type;

endpackage

[rtl/brwt_front.sv]
// ----------------------------------------------------------------------------
// brwt_front
// Accepts commands, checks the register spec, applies offset and length.
// ----------------------------------------------------------------------------
module brwt_front
   import brwt_pkg::*;
#(
   parameter int ADDR_WIDTH = 32,
   parameter int CW         = 32
) (
   input  logic           start,
   input  logic           full,
   input  req_type        req_data,
   output logic           push,
   output queue_item_type item,
   output logic [CW-1:0]  item_addr
);

   localparam logic [CW-1:0] AMASK = {CW{1'b1}} >> (CW - ADDR_WIDTH);

   logic compat;

   assign push   = start && !full;
   assign compat = req_data.req_space > 32'd1;

   always_comb begin
      item.entry_index      = req_data.entry_index;
      item.win_child_space  = req_data.win_child_space;
      item.win_child_base   = req_data.win_child_base;
      item.win_parent_space = req_data.win_parent_space;
      item.win_parent_base  = req_data.win_parent_base;
      item.win_size         = req_data.win_size;
      item.xl_size          = (req_data.req_len != 32'd0) ? req_data.req_len
                                                          : req_data.req_size;
      if (compat) begin
         item.xl_space = req_data.req_space + req_data.req_offset;
         item_addr     = CW'(req_data.req_addr);
      end else begin
         item.xl_space = req_data.req_space;
         item_addr     = (CW'(req_data.req_addr) + CW'(req_data.req_offset)) & AMASK;
      end
      priority if (req_data.opcode == OP_LOAD) begin
         item.kind = KIND_LOAD;
      end else if (compat && req_data.req_addr != 32'd0) begin
         item.kind = KIND_INVALID;
      end else begin
         item.kind = KIND_XLATE;
      end
   end

endmodule

[rtl/brwt_queue.sv]
// ----------------------------------------------------------------------------
// brwt_queue
// Small FIFO between the command front and the lookup back end.
// ----------------------------------------------------------------------------
module brwt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full      = count_ff == NW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_data = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/brwt_back.sv]
// ----------------------------------------------------------------------------
// brwt_back
// Window table, parallel window match, rebase and result register.
// ----------------------------------------------------------------------------
module brwt_back
   import brwt_pkg::*;
#(
   parameter int MAX_RANGES = 8,
   parameter int ADDR_WIDTH = 32,
   parameter int CW         = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_WIDTH-1:0] csr_data,
   input  logic                 item_valid,
   input  queue_item_type       item,
   input  logic [CW-1:0]        item_addr,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam logic [CW-1:0] AMASK = {CW{1'b1}} >> (CW - ADDR_WIDTH);
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   logic [31:0]     tab_child_space_ff  [MAX_RANGES];
   logic [31:0]     tab_child_base_ff   [MAX_RANGES];
   logic [31:0]     tab_parent_space_ff [MAX_RANGES];
   logic [CW-1:0]   tab_delta_ff        [MAX_RANGES];
   logic [CW-1:0]   tab_win_last_ff     [MAX_RANGES];
   logic [MAX_RANGES-1:0] tab_whole_ff;

   logic [CSR_WIDTH-1:0] range_count_ff;

   logic                  load_en;
   logic [CW-1:0]         load_base;
   logic [CW-1:0]         load_win_last;
   logic [CW-1:0]         load_delta;
   logic [CW-1:0]         spec_last;
   logic [MAX_RANGES-1:0] match;
   logic [IW-1:0]         match_idx;

   logic          a_valid_ff, a_valid_in;
   kind_type      a_kind_ff;
   logic          a_hit_ff;
   logic          a_bypass_ff;
   logic [IW-1:0] a_idx_ff;
   logic [31:0]   a_space_ff;
   logic [CW-1:0] a_addr_ff;
   logic [31:0]   a_size_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [CW-1:0] rebased;

   assign load_en       = item_valid && item.kind == KIND_LOAD;
   assign load_base     = CW'(item.win_child_base);
   assign load_win_last = (load_base + CW'(item.win_size) - CW'(1)) & AMASK;
   assign load_delta    = (CW'(item.win_parent_base) - load_base) & AMASK;
   assign spec_last     = (item_addr + CW'(item.xl_size) - CW'(1)) & AMASK;

   always_comb begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         match[i] = (32'(range_count_ff) > i)
                 && (item.xl_space == tab_child_space_ff[i])
                 && (item_addr >= CW'(tab_child_base_ff[i]))
                 && (tab_whole_ff[i] || spec_last <= tab_win_last_ff[i]);
      end
      match_idx = '0;
      for (int i = MAX_RANGES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         if (load_en && 32'(item.entry_index) == i) begin
            tab_child_space_ff[i]  <= item.win_child_space;
            tab_child_base_ff[i]   <= item.win_child_base;
            tab_parent_space_ff[i] <= item.win_parent_space;
            tab_delta_ff[i]        <= load_delta;
            tab_win_last_ff[i]     <= load_win_last;
            tab_whole_ff[i]        <= item.win_size == 32'd0;
         end
      end
   end

   assign a_valid_in = item_valid && item.kind != KIND_LOAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            range_count_ff <= csr_data;
         end
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_in) begin
         a_kind_ff   <= item.kind;
         a_hit_ff    <= |match;
         a_bypass_ff <= range_count_ff == '0;
         a_idx_ff    <= match_idx;
         a_space_ff  <= item.xl_space;
         a_addr_ff   <= item_addr;
         a_size_ff   <= item.xl_size;
      end
      if (a_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rebased = (a_addr_ff + tab_delta_ff[a_idx_ff]) & AMASK;

   always_comb begin
      rsp_data_in = '0;
      unique case (a_kind_ff)
         KIND_XLATE: begin
            priority if (a_bypass_ff) begin
               rsp_data_in.status    = STATUS_OK;
               rsp_data_in.out_space = a_space_ff;
               rsp_data_in.out_addr  = a_addr_ff[31:0];
               rsp_data_in.out_size  = a_size_ff;
            end else if (a_hit_ff) begin
               rsp_data_in.status    = STATUS_OK;
               rsp_data_in.out_space = tab_parent_space_ff[a_idx_ff];
               rsp_data_in.out_addr  = rebased[31:0];
               rsp_data_in.out_size  = a_size_ff;
            end else begin
               rsp_data_in.status = STATUS_RANGE;
            end
         end
         KIND_INVALID: rsp_data_in.status = STATUS_INVALID;
         default:      rsp_data_in = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/bus_range_window_translate.sv]
// ----------------------------------------------------------------------------
// bus_range_window_translate
// Results pass the queue, match stage and result register; loads give none.
// Throughput: one command per cycle; all windows are matched in parallel in the
// back end, which pops one queue entry every cycle.
// Reset: synchronous; clears the queue, pipeline valids and range_count.
// Table entries are undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bus_range_window_translate
   import brwt_pkg::*;
#(
   parameter int MAX_RANGES = 8,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_WIDTH-1:0] csr_data
);

   localparam int CW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
   localparam int QW = $bits(queue_item_type) + CW;

   logic           push;
   queue_item_type f_item;
   logic [CW-1:0]  f_addr;
   logic           q_full;
   logic           q_valid;
   logic [QW-1:0]  q_data;
   queue_item_type q_item;
   logic [CW-1:0]  q_addr;
   logic           csr_write;

   assign busy      = q_full;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign q_item    = queue_item_type'(q_data[QW-1:CW]);
   assign q_addr    = q_data[CW-1:0];

   brwt_front #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .CW         (CW)
   ) u_front (
      .start     (start),
      .full      (q_full),
      .req_data  (req_data),
      .push      (push),
      .item      (f_item),
      .item_addr (f_addr)
   );

   brwt_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_item, f_addr}),
      .pop       (q_valid),
      .full      (q_full),
      .not_empty (q_valid),
      .head_data (q_data)
   );

   brwt_back #(
      .MAX_RANGES (MAX_RANGES),
      .ADDR_WIDTH (ADDR_WIDTH),
      .CW         (CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_data   (csr_data),
      .item_valid (q_valid),
      .item       (q_item),
      .item_addr  (q_addr),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/brwt_checker.sv]
// ----------------------------------------------------------------------------
// brwt_checker
// Port-level checks of the range window translation block.
// ----------------------------------------------------------------------------
module brwt_checker
   import brwt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic xfer;

   assign xfer = start && !busy;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_xlate_result: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_data.opcode == OP_XLATE) |-> ##3 rsp_valid)
      else $error("translate transfer without result");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_data.opcode == OP_LOAD) |-> ##3 !rsp_valid)
      else $error("load transfer produced a result");

   a_invalid_spec: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_data.opcode == OP_XLATE && req_data.req_space > 32'd1
       && req_data.req_addr != 32'd0)
      |-> ##3 (rsp_valid && rsp_data.status == STATUS_INVALID))
      else $error("invalid spec not flagged");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK)
      |-> (rsp_data.out_space == 32'd0 && rsp_data.out_addr == 32'd0
           && rsp_data.out_size == 32'd0))
      else $error("error result carries nonzero fields");

endmodule

bind bus_range_window_translate brwt_checker u_brwt_checker (.*);

[tb/tb_bus_range_window_translate.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bus_range_window_translate
// Self-checking bench for the range window translation block. Windows are
// loaded through the command port, and the window count is set through the
// csr channel while the block is idle. A local predictor keeps its own copy
// of the window table and computes every translation at its command
// transfer. A checker compares each result strobe against the oldest
// prediction. Directed cases come first, then randomized traffic with
// sender gaps, and a closing burst with no gaps.
// ----------------------------------------------------------------------------
module tb_bus_range_window_translate;
   import brwt_pkg::*;

   localparam int TABLE_DEPTH  = 8;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 800;
   localparam int BURST_ITEMS  = 100;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data;

   logic [31:0]          tab_cs [TABLE_DEPTH];
   logic [31:0]          tab_cb [TABLE_DEPTH];
   logic [31:0]          tab_ps [TABLE_DEPTH];
   logic [31:0]          tab_pb [TABLE_DEPTH];
   logic [31:0]          tab_sz [TABLE_DEPTH];
   logic [CSR_WIDTH-1:0] window_count;
   rsp_type              pending_translations[$];
   int                   mismatch_count;
   bit                   gaps_on;

   bus_range_window_translate DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("bus_range_window_translate verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("%0t ns: %s: got %08h expected %08h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Predicted translation for one spec against the current table and count.
   function automatic rsp_type translate_spec(input req_type r);
      rsp_type     res;
      logic [31:0] sp;
      logic [31:0] ad;
      logic [31:0] sz;
      logic [31:0] last;
      logic [31:0] wlast;
      int          n;
      int          found;
      res = '0;
      sp = r.req_space;
      ad = r.req_addr;
      sz = r.req_size;
      if (sp > 1 && ad != 0) begin
         res.status = STATUS_INVALID;
         return res;
      end
      if (sp > 1) begin
         sp = sp + r.req_offset;
      end else begin
         ad = ad + r.req_offset;
      end
      if (r.req_len != 0) begin
         sz = r.req_len;
      end
      n = (window_count > TABLE_DEPTH) ? TABLE_DEPTH : window_count;
      if (n != 0) begin
         found = -1;
         for (int k = 0; k < n; k++) begin
            last  = ad + sz - 32'd1;
            wlast = tab_cb[k] + tab_sz[k] - 32'd1;
            if (found < 0 && sp == tab_cs[k] && ad >= tab_cb[k] &&
                (tab_sz[k] == 0 || last <= wlast)) begin
               found = k;
            end
         end
         if (found < 0) begin
            res.status = STATUS_RANGE;
            return res;
         end
         sp = tab_ps[found];
         ad = ad + tab_pb[found] - tab_cb[found];
      end
      res.status    = STATUS_OK;
      res.out_space = sp;
      res.out_addr  = ad;
      res.out_size  = sz;
      return res;
   endfunction

   function automatic req_type noise_item();
      req_type r;
      r.opcode           = 1'($urandom);
      r.entry_index      = 3'($urandom);
      r.win_child_space  = $urandom;
      r.win_child_base   = $urandom;
      r.win_parent_space = $urandom;
      r.win_parent_base  = $urandom;
      r.win_size         = $urandom;
      r.req_space        = $urandom;
      r.req_addr         = $urandom;
      r.req_size         = $urandom;
      r.req_offset       = $urandom;
      r.req_len          = $urandom;
      return r;
   endfunction

   function automatic req_type load_item(input logic [2:0] idx, input logic [31:0] cs,
                                         input logic [31:0] cb, input logic [31:0] ps,
                                         input logic [31:0] pb, input logic [31:0] sz);
      req_type r;
      r = noise_item();
      r.opcode           = OP_LOAD;
      r.entry_index      = idx;
      r.win_child_space  = cs;
      r.win_child_base   = cb;
      r.win_parent_space = ps;
      r.win_parent_base  = pb;
      r.win_size         = sz;
      return r;
   endfunction

   function automatic req_type xlate_item(input logic [31:0] sp, input logic [31:0] ad,
                                          input logic [31:0] sz, input logic [31:0] off,
                                          input logic [31:0] len);
      req_type r;
      r = noise_item();
      r.opcode     = OP_XLATE;
      r.req_space  = sp;
      r.req_addr   = ad;
      r.req_size   = sz;
      r.req_offset = off;
      r.req_len    = len;
      return r;
   endfunction

   function automatic req_type random_window();
      logic [31:0] cs;
      logic [31:0] cb;
      logic [31:0] sz;
      case ($urandom_range(0, 7))
         0, 1:    cs = 32'd0;
         2, 3:    cs = 32'd1;
         4:       cs = $urandom_range(2, 20);
         5:       cs = 32'hFFFF_FFFF;
         default: cs = $urandom;
      endcase
      case ($urandom_range(0, 3))
         0:       cb = 32'd0;
         1:       cb = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
         default: cb = $urandom;
      endcase
      if (cs > 1 && $urandom_range(0, 3) != 0) begin
         cb = 32'd0;
      end
      case ($urandom_range(0, 4))
         0:       sz = 32'd0;
         1:       sz = $urandom;
         2:       sz = $urandom_range(1, 32'h10_0000);
         default: sz = $urandom_range(1, 32'h1000);
      endcase
      return load_item(3'($urandom), cs, cb, $urandom, $urandom, sz);
   endfunction

   function automatic req_type random_translate();
      req_type     r;
      int          j;
      logic [31:0] span;
      logic [31:0] target;
      logic [31:0] sz;
      r = noise_item();
      r.opcode = OP_XLATE;
      j = $urandom_range(0, TABLE_DEPTH - 1);
      sz = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 16);
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            r.req_space = $urandom_range(2, 9);
            if (r.req_addr == 0) begin
               r.req_addr = 32'd1;
            end
         end
         2: begin
            r.req_space  = $urandom | 32'd2;
            r.req_addr   = 32'd0;
            r.req_offset = tab_cs[j] - r.req_space;
            r.req_size   = sz;
            r.req_len    = $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 64);
         end
         default: begin
            span = (tab_sz[j] == 0) ? $urandom : tab_sz[j];
            if (span == 0) begin
               span = 32'd1;
            end
            if ($urandom_range(0, 3) == 0) begin
               target = tab_cb[j] + span - $urandom_range(1, 20);
            end else begin
               target = tab_cb[j] + ($urandom % span);
            end
            r.req_space  = (tab_cs[j] > 1) ? $urandom_range(0, 1) : tab_cs[j];
            r.req_offset = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            r.req_addr   = target - r.req_offset;
            if ($urandom_range(0, 1)) begin
               r.req_len  = 32'd0;
               r.req_size = sz;
            end else begin
               r.req_len  = (sz == 0) ? $urandom : sz;
            end
         end
      endcase
      return r;
   endfunction

   // Drives one command and holds it until the block takes the transfer.
   task automatic send_cmd(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (r.opcode == OP_XLATE) begin
         pending_translations.push_back(translate_spec(r));
      end else begin
         tab_cs[r.entry_index] = r.win_child_space;
         tab_cb[r.entry_index] = r.win_child_base;
         tab_ps[r.entry_index] = r.win_parent_space;
         tab_pb[r.entry_index] = r.win_parent_base;
         tab_sz[r.entry_index] = r.win_size;
      end
   endtask

   task automatic sender_gap();
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // Loads leave no result, so let the pipeline drain past the last one too.
   task automatic quiesce();
      start <= 1'b0;
      while (pending_translations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_count(input logic [CSR_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      window_count = value;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_translations.size() == 0) begin
            report_mismatch("unexpected result, addr", rsp_data.out_addr, 32'd0);
         end else begin
            want = pending_translations.pop_front();
            if (rsp_data.status != want.status) begin
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
            if (rsp_data.out_space != want.out_space) begin
               report_mismatch("out_space", rsp_data.out_space, want.out_space);
            end
            if (rsp_data.out_addr != want.out_addr) begin
               report_mismatch("out_addr", rsp_data.out_addr, want.out_addr);
            end
            if (rsp_data.out_size != want.out_size) begin
               report_mismatch("out_size", rsp_data.out_size, want.out_size);
            end
         end
      end
   end

   // Every entry is written before any nonzero count, so no search reads an
   // unloaded window.
   task automatic test_table_load();
      send_cmd(load_item(3'd0, 32'd0, 32'h0000_1000, 32'd0, 32'h8000_0000, 32'h1000));
      send_cmd(load_item(3'd1, 32'd0, 32'h0000_1800, 32'd1, 32'h0000_0010, 32'h100));
      send_cmd(load_item(3'd2, 32'd1, 32'd0, 32'd0, 32'hFFFF_F000, 32'd0));
      send_cmd(load_item(3'd3, 32'd7, 32'd0, 32'd1, 32'h0000_03F8, 32'd8));
      send_cmd(load_item(3'd4, 32'd0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h100, 32'h100));
      send_cmd(load_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_cmd(load_item(3'd6, 32'h5A, 32'd0, 32'd0, 32'd0, 32'd0));
      send_cmd(load_item(3'd7, 32'd0, 32'h2000_0000, 32'd0, 32'h3000_0000, 32'h10));
      quiesce();
   endtask

   task automatic test_pass_through();
      write_window_count(4'd0);
      send_cmd(xlate_item(32'd0, 32'hFFFF_FFF0, 32'd4, 32'h20, 32'd0));
      send_cmd(xlate_item(32'd9, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0));
      send_cmd(xlate_item(32'd2, 32'd5, 32'd4, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd1, 32'h1234, 32'hFFFF_FFFF, 32'd0, 32'h40));
      quiesce();
   endtask

   task automatic test_window_search();
      write_window_count(4'd8);
      send_cmd(xlate_item(32'd0, 32'h1004, 32'd4, 32'd0, 32'd0));
      // overlapping windows: the lower entry wins
      send_cmd(xlate_item(32'd0, 32'h1800, 32'd4, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd0, 32'h1FFC, 32'd4, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd0, 32'h1FFE, 32'd4, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd1, 32'h1234, 32'd2, 32'h10, 32'd0));
      send_cmd(xlate_item(32'd3, 32'd0, 32'd1, 32'd4, 32'd0));
      send_cmd(xlate_item(32'd0, 32'h2000_0000, 32'd0, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd0, 32'h2000_0008, 32'h100, 32'd0, 32'd8));
      quiesce();
   endtask

   task automatic test_count_clamp();
      write_window_count(4'd15);
      send_cmd(xlate_item(32'd0, 32'hFFFF_FF80, 32'h80, 32'd0, 32'd0));
      quiesce();
      write_window_count(4'd1);
      send_cmd(xlate_item(32'd0, 32'h1800, 32'd4, 32'd0, 32'd0));
      send_cmd(xlate_item(32'd0, 32'h2000_0000, 32'd4, 32'd0, 32'd0));
      quiesce();
   endtask

   task automatic test_random_traffic(input int count, input bit allow_gaps);
      for (int i = 0; i < count; i++) begin
         if (i % 120 == 119) begin
            quiesce();
            case ($urandom_range(0, 5))
               0:       write_window_count(4'd0);
               1:       write_window_count(4'd15);
               2:       write_window_count(4'($urandom_range(1, 7)));
               3:       write_window_count(4'($urandom_range(9, 15)));
               default: write_window_count(4'd8);
            endcase
         end
         if (i % 40 == 0) begin
            gaps_on = $urandom_range(0, 2) != 0;
         end
         case ($urandom_range(0, 19))
            0, 1:    send_cmd(random_window());
            2:       send_cmd(noise_item());
            default: send_cmd(random_translate());
         endcase
         if (allow_gaps && gaps_on && $urandom_range(0, 3) == 0) begin
            sender_gap();
         end
      end
   endtask

   task automatic test_closing_burst();
      quiesce();
      write_window_count(4'd8);
      test_random_traffic(BURST_ITEMS, 1'b0);
   endtask

   initial begin
      mismatch_count = 0;
      gaps_on        = 1'b1;
      window_count   = '0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_pass_through();
      test_window_search();
      test_count_clamp();
      write_window_count(4'd8);
      test_random_traffic(RANDOM_ITEMS, 1'b1);
      test_closing_burst();

      start <= 1'b0;
      for (int w = 0; w < 1000 && pending_translations.size() != 0; w++) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_translations.size() != 0) begin
         report_mismatch("results never returned", pending_translations.size(), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("bus_range_window_translate verification clean");
      end else begin
         $display("bus_range_window_translate verification failed");
      end
      $finish;
   end

endmodule
